[design/scot_pkg.sv]
// Shared types and constants for the segment/circle crossing test.
package scot_pkg;

  localparam int CW = 32;

  typedef enum logic {
    REQ_LOAD  = 1'b0,
    REQ_QUERY = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_ISSUE = 2'd1,
    ST_DRAIN = 2'd2,
    ST_OUT   = 2'd3
  } state_t;

  // one obstacle test travelling down the circle pipeline
  typedef struct packed {
    logic          vld;
    logic          last;
    logic signed [CW-1:0] x1;
    logic signed [CW-1:0] y1;
    logic signed [CW-1:0] x2;
    logic signed [CW-1:0] y2;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic        [CW-2:0] r;
  } circ_req_t;

  typedef struct packed {
    logic vld;
    logic last;
    logic hit;
  } circ_res_t;

endpackage

[design/scot_circle.sv]
// Pipelined segment versus one circle crossing test, one circle per cycle while adv is high.
module scot_circle (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  scot_pkg::circ_req_t  req,
  output scot_pkg::circ_res_t  res
);
  import scot_pkg::*;

  localparam int DW  = CW + 1;       // differences
  localparam int PW  = 2 * DW;       // products of differences
  localparam int SW  = PW + 2;       // sums of squares minus r^2
  localparam int UW  = PW - 1;       // magnitudes of a, -b and g0 on the vertex path
  localparam int LW  = 32;           // low limb
  localparam int HW  = UW - LW;      // high limb
  localparam int HHW = 2 * HW;
  localparam int HLW = HW + LW;
  localparam int LLW = 2 * LW;
  localparam int MW  = 2 * UW + 1;   // b^2 and a*g0

  // stage 1: differences
  logic                 v1_r, l1_r, dz1_r;
  logic signed [DW-1:0] dx1_r, dy1_r, fx1_r, fy1_r, hx1_r, hy1_r;
  logic        [CW-2:0] r1_r;
  // stage 2: products
  logic                 v2_r, l2_r, dz2_r;
  logic signed [PW-1:0] dxx2_r, dyy2_r, fxx2_r, fyy2_r, hxx2_r, hyy2_r;
  logic signed [PW-1:0] dfx2_r, dfy2_r, rr2_r;
  // stage 3: sums
  logic                 v3_r, l3_r, dz3_r;
  logic signed [SW-1:0] a3_r, g03_r, g13_r, b3_r;
  // stage 4: decisions and limb products
  logic                 v4_r, l4_r, early4_r, need4_r;
  logic [HHW-1:0]       bhh4_r, ahh4_r;
  logic [HLW-1:0]       bhl4_r, ahl4_r, alh4_r;
  logic [LLW-1:0]       bll4_r, all4_r;
  // stage 5: full products
  logic                 v5_r, l5_r, early5_r, need5_r;
  logic [MW-1:0]        bb5_r, ag5_r;
  // stage 6: result
  logic                 v6_r, l6_r, h6_r;

  logic n0, n1, z0, z1, early, need;
  logic signed [SW-1:0] nb;

  always_comb begin
    n0 = g03_r[SW-1];
    n1 = g13_r[SW-1];
    z0 = (g03_r == '0);
    z1 = (g13_r == '0);
    nb = -b3_r;
    early = ((n0 || z0) && !n1) || (!n0 && (n1 || z1));
    // both outside: vertex must lie within [0,1]
    need = !n0 && !n1 && !nb[SW-1] && !((a3_r - nb) < 0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0; v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (adv) begin
      v1_r <= req.vld; v2_r <= v1_r; v3_r <= v2_r; v4_r <= v3_r; v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      l1_r  <= req.last;
      dz1_r <= (req.x1 == req.x2) && (req.y1 == req.y2);
      dx1_r <= DW'(req.x2) - DW'(req.x1);
      dy1_r <= DW'(req.y2) - DW'(req.y1);
      fx1_r <= DW'(req.x1) - DW'(req.cx);
      fy1_r <= DW'(req.y1) - DW'(req.cy);
      hx1_r <= DW'(req.x2) - DW'(req.cx);
      hy1_r <= DW'(req.y2) - DW'(req.cy);
      r1_r  <= req.r;

      l2_r   <= l1_r;
      dz2_r  <= dz1_r;
      dxx2_r <= PW'(dx1_r) * PW'(dx1_r);
      dyy2_r <= PW'(dy1_r) * PW'(dy1_r);
      fxx2_r <= PW'(fx1_r) * PW'(fx1_r);
      fyy2_r <= PW'(fy1_r) * PW'(fy1_r);
      hxx2_r <= PW'(hx1_r) * PW'(hx1_r);
      hyy2_r <= PW'(hy1_r) * PW'(hy1_r);
      dfx2_r <= PW'(dx1_r) * PW'(fx1_r);
      dfy2_r <= PW'(dy1_r) * PW'(fy1_r);
      rr2_r  <= PW'($signed({1'b0, r1_r})) * PW'($signed({1'b0, r1_r}));

      l3_r  <= l2_r;
      dz3_r <= dz2_r;
      a3_r  <= SW'(dxx2_r) + SW'(dyy2_r);
      g03_r <= SW'(fxx2_r) + SW'(fyy2_r) - SW'(rr2_r);
      g13_r <= SW'(hxx2_r) + SW'(hyy2_r) - SW'(rr2_r);
      b3_r  <= SW'(dfx2_r) + SW'(dfy2_r);

      // on the vertex path a, -b and g0 are all non-negative and below 2^65
      l4_r     <= l3_r;
      early4_r <= !dz3_r && early;
      need4_r  <= !dz3_r && need;
      bhh4_r   <= HHW'(nb[UW-1:LW]) * HHW'(nb[UW-1:LW]);
      bhl4_r   <= HLW'(nb[UW-1:LW]) * HLW'(nb[LW-1:0]);
      bll4_r   <= LLW'(nb[LW-1:0]) * LLW'(nb[LW-1:0]);
      ahh4_r   <= HHW'(a3_r[UW-1:LW]) * HHW'(g03_r[UW-1:LW]);
      ahl4_r   <= HLW'(a3_r[UW-1:LW]) * HLW'(g03_r[LW-1:0]);
      alh4_r   <= HLW'(a3_r[LW-1:0]) * HLW'(g03_r[UW-1:LW]);
      all4_r   <= LLW'(a3_r[LW-1:0]) * LLW'(g03_r[LW-1:0]);

      l5_r     <= l4_r;
      early5_r <= early4_r;
      need5_r  <= need4_r;
      bb5_r    <= (MW'(bhh4_r) << (2 * LW)) + (MW'(bhl4_r) << (LW + 1)) + MW'(bll4_r);
      ag5_r    <= (MW'(ahh4_r) << (2 * LW)) + ((MW'(ahl4_r) + MW'(alh4_r)) << LW)
                  + MW'(all4_r);

      l6_r <= l5_r;
      h6_r <= early5_r || (need5_r && (bb5_r >= ag5_r));
    end
  end

  assign res = '{vld: v6_r, last: l6_r, hit: h6_r};

endmodule

[design/segment_circle_obstacle_test.sv]
// Top level: obstacle table, query sequencer and circle test pipeline.
//
// Input channel in_*: a beat with in_req_type 0 loads table entry
// in_threat_index with centre and radius and gives no result. A beat with
// in_req_type 1 queries a segment and gives one out_hit beat.
// cfg_*: writes threat_count, the number of entries a query tests (values
// above MAX_THREATS test all entries). Write only while the block is idle.
// A load leaves the block idle. A query issues one table entry per cycle
// while out_stall does not freeze the pipeline, through a registered table
// read, into a six-stage circle test pipeline; in_stall stays high from the
// query beat until out_valid rises, and with a tested count of zero the
// query goes straight to the output state.
// The entries are walked through the single table read port.
// The hit is held in an output register; while out_stall is high with a
// hit waiting the pipeline freezes. A further beat may still be taken while
// the block is idle, nothing is lost.
// Reset (rst_n low, synchronous) clears threat_count and the control;
// table contents are undefined until loaded, reading them is not allowed.
module segment_circle_obstacle_test #(
  parameter int MAX_THREATS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_req_type,
  input  logic [3:0]  in_threat_index,
  input  logic signed [31:0] in_threat_x,
  input  logic signed [31:0] in_threat_y,
  input  logic [30:0] in_threat_radius,
  input  logic signed [31:0] in_seg_x1,
  input  logic signed [31:0] in_seg_y1,
  input  logic signed [31:0] in_seg_x2,
  input  logic signed [31:0] in_seg_y2,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_threat_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_hit
);
  import scot_pkg::*;

  localparam int IW = (MAX_THREATS > 1) ? $clog2(MAX_THREATS) : 1;
  localparam int NW = $clog2(MAX_THREATS + 1);

  logic signed [CW-1:0] cx_mem [MAX_THREATS];
  logic signed [CW-1:0] cy_mem [MAX_THREATS];
  logic        [CW-2:0] r_mem  [MAX_THREATS];

  logic [4:0]  count_r;
  state_t      state_r, state_nxt;
  logic [NW-1:0] idx_r, idx_nxt, n_r, n_nxt;
  logic signed [CW-1:0] x1_r, y1_r, x2_r, y2_r;
  logic        hit_r, hit_nxt, out_valid_r, out_hit_r;
  logic        adv, in_acc, issue, rd_vld_r, rd_last_r, rd_zero_r;
  logic signed [CW-1:0] rcx_r, rcy_r;
  logic        [CW-2:0] rr_r;
  circ_req_t   creq;
  circ_res_t   cres;
  logic [NW-1:0] n_eff;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign adv       = !(out_valid_r && out_stall);
  assign issue     = (state_r == ST_ISSUE) && adv;

  always_comb begin
    if (32'(count_r) > MAX_THREATS) n_eff = NW'(MAX_THREATS);
    else                            n_eff = NW'(count_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) count_r <= '0;
    else if (cfg_valid && cfg_ready) count_r <= cfg_threat_count;
  end

  // table write and registered read
  always_ff @(posedge clk) begin
    if (in_acc && in_req_type == REQ_LOAD && 32'(in_threat_index) < MAX_THREATS) begin
      cx_mem[IW'(in_threat_index)] <= in_threat_x;
      cy_mem[IW'(in_threat_index)] <= in_threat_y;
      r_mem[IW'(in_threat_index)]  <= in_threat_radius;
    end
    if (issue) begin
      rcx_r <= cx_mem[IW'(idx_r)];
      rcy_r <= cy_mem[IW'(idx_r)];
      rr_r  <= r_mem[IW'(idx_r)];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_acc && in_req_type == REQ_QUERY)
                  state_nxt = (n_eff == '0) ? ST_OUT : ST_ISSUE;
      ST_ISSUE: if (adv && idx_r + 1'b1 == n_r) state_nxt = ST_DRAIN;
      ST_DRAIN: if (adv && cres.vld && cres.last) state_nxt = ST_OUT;
      ST_OUT:   if (adv) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // datapath and output control
  always_comb begin
    idx_nxt = idx_r;
    n_nxt   = n_r;
    hit_nxt = hit_r;
    case (state_r)
      ST_IDLE: begin
        idx_nxt = '0;
        n_nxt   = n_eff;
        hit_nxt = 1'b0;
      end
      ST_ISSUE: if (adv) idx_nxt = idx_r + 1'b1;
      ST_DRAIN: if (adv && cres.vld && cres.hit) hit_nxt = 1'b1;
      ST_OUT: ;
      default: ;
    endcase
    if (state_r == ST_ISSUE && adv && cres.vld && cres.hit) hit_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      rd_vld_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (adv) begin
        out_valid_r <= (state_r == ST_OUT);
        rd_vld_r    <= issue;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    n_r   <= n_nxt;
    hit_r <= hit_nxt;
    if (adv) out_hit_r <= hit_r;
    if (adv) rd_last_r <= (idx_r + 1'b1 == n_r);
    rd_zero_r <= 1'b0;
    if (in_acc) begin
      x1_r <= in_seg_x1; y1_r <= in_seg_y1;
      x2_r <= in_seg_x2; y2_r <= in_seg_y2;
    end
  end

  always_comb begin
    creq.vld  = rd_vld_r && !rd_zero_r;
    creq.last = rd_last_r;
    creq.x1 = x1_r; creq.y1 = y1_r; creq.x2 = x2_r; creq.y2 = y2_r;
    creq.cx = rcx_r; creq.cy = rcy_r; creq.r = rr_r;
  end

  scot_circle u_circle (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .req   (creq),
    .res   (cres)
  );

  assign out_valid = out_valid_r;
  assign out_hit   = out_hit_r;

endmodule

[design/scot_checker.sv]
// Port-level checks for the segment/circle crossing test.
module scot_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic in_req_type,
  input logic out_valid,
  input logic out_stall,
  input logic out_hit
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_hit))
    else $error("result beat dropped under stall");

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_req_type |=> in_stall)
    else $error("query accepted without going busy");

  // a query taken while an earlier result still waits leaves that result up
  a_no_result_early: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_req_type && !(out_valid && out_stall) |=> !out_valid)
    else $error("result too soon after query");

  a_load_quick: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_req_type |=> !in_stall)
    else $error("load held the input side");
endmodule

bind segment_circle_obstacle_test scot_checker u_scot_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .in_req_type(in_req_type), .out_valid(out_valid), .out_stall(out_stall),
  .out_hit(out_hit)
);
